[rtl/core/alist_pkg.sv]
// Shared types and constants for the array list engine.
`timescale 1ns / 1ps

package alist_pkg;

	localparam int CAPACITY  = 64;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	typedef logic [2:0]           func_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	// Request operation codes
	localparam func_t FN_APPEND       = 3'd0;
	localparam func_t FN_INSERT       = 3'd1;
	localparam func_t FN_REMOVE       = 3'd2;
	localparam func_t FN_SET          = 3'd3;
	localparam func_t FN_GET          = 3'd4;
	localparam func_t FN_RESET_CURSOR = 3'd5;
	localparam func_t FN_NEXT         = 3'd6;

	// Store port request: one write and one read per cycle
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		logic  re;
		idx_t  raddr;
	} mem_req_t;

	// One finished result
	typedef struct packed {
		logic                        status;
		logic signed [WORD_BITS-1:0] read_value;
		cnt_t                        length;
		logic                        has_next;
	} res_t;

endpackage

[rtl/core/alist_ifs.sv]
// Request and response channel interfaces for the array list engine.
`timescale 1ns / 1ps

interface alist_req_if;
	import alist_pkg::*;

	logic                        valid;
	logic                        ready;
	func_t                       func;
	idx_t                        position;
	logic signed [WORD_BITS-1:0] value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink (input valid, input func, input position, input value, output ready);
endinterface

interface alist_rsp_if;
	import alist_pkg::*;

	logic                        valid;
	logic                        ready;
	logic                        status;
	logic signed [WORD_BITS-1:0] read_value;
	cnt_t                        length;
	logic                        has_next;

	modport source (output valid, output status, output read_value, output length,
		output has_next, input ready);
	modport sink (input valid, input status, input read_value, input length,
		input has_next, output ready);
endinterface

[rtl/core/array_list_engine_top.sv]
// Top level of the array list engine: sequencer, element store, response register.
`timescale 1ns / 1ps

// Array list engine: an ordered list of up to CAPACITY signed words.
// Channels: req carries func, position and value; rsp returns status,
// read_value, length and has_next, one transfer per request. Both use a
// valid/ready handshake; a transfer happens when valid and ready are high
// at a rising edge of clk.
// Throughput: one request at a time; req.ready is high only while the
// sequencer is idle. Append, set, get, next, cursor reset and failing
// requests go from the sequencer's response state to the rsp register,
// which raises rsp.valid. Insert and remove shift entries through the
// single store port, one entry per cycle; insert then writes the new
// value, and both then take the same response path. The shift loop and
// the one-read, one-write store set how long they take.
// Stall: the result sits in the rsp register until rsp.ready; a second
// finished result waits in the sequencer, which then takes no request.
// Reset (arst_n low): the list is empty, the cursor is at the start and
// rsp.valid is low. The store is not cleared; only entries below the
// count are ever read.
module array_list_engine_top (
	input logic        clk,
	input logic        arst_n,
	alist_req_if.sink  req,
	alist_rsp_if.source rsp
);
	import alist_pkg::*;

	mem_req_t mreq;
	word_t    rdata;
	res_t     res;
	logic     res_valid;
	logic     res_take;

	res_t     out_q;
	logic     ov_q;

	alist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mreq      (mreq),
		.rdata     (rdata),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (res_take)
	);

	alist_store u_store (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	// Load the response register when it is empty or being drained
	assign res_take = res_valid && (!ov_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			out_q <= '0;
		end else begin
			if (res_take) begin
				ov_q  <= 1'b1;
				out_q <= res;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.status     = out_q.status;
	assign rsp.read_value = out_q.read_value;
	assign rsp.length     = out_q.length;
	assign rsp.has_next   = out_q.has_next;

endmodule

[rtl/core/alist_store.sv]
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module alist_store (
	input  logic               clk,
	input  alist_pkg::mem_req_t mreq,
	output alist_pkg::word_t   rdata
);
	import alist_pkg::*;

	word_t mem_q [CAPACITY];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem_q[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			rdata_q <= mem_q[mreq.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/alist_ctrl.sv]
// Request sequencer: checks, count and cursor, and the entry move loop.
`timescale 1ns / 1ps

module alist_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	alist_req_if.sink           req,
	output alist_pkg::mem_req_t mreq,
	input  alist_pkg::word_t    rdata,
	output alist_pkg::res_t     res,
	output logic                res_valid,
	input  logic                res_take
);
	import alist_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE,
		ST_PLACE,
		ST_RESP
	} state_t;

	state_t state_q;
	cnt_t   count_q;
	cnt_t   cursor_q;
	cnt_t   left_q;
	idx_t   pos_q;
	idx_t   idx_q;
	idx_t   dst_q;
	word_t  val_q;
	logic   ins_q;
	logic   pend_q;
	logic   fail_q;
	logic   rd_q;

	logic acc;
	logic full;
	logic pos_in;
	logic pos_le;
	logic nxt_ok;
	cnt_t pos_ext;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign pos_ext   = {1'b0, req.position};
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign pos_in    = (pos_ext < count_q);
	assign pos_le    = (pos_ext <= count_q);
	assign nxt_ok    = (cursor_q < count_q);

	// Store port: single writes and reads at accept, moves, final insert write
	always_comb begin
		mreq = '0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (req.func)
						FN_APPEND: begin
							mreq.we    = !full;
							mreq.waddr = count_q[IDX_W-1:0];
							mreq.wdata = word_t'(req.value);
						end
						FN_SET: begin
							mreq.we    = pos_in;
							mreq.waddr = req.position;
							mreq.wdata = word_t'(req.value);
						end
						FN_GET: begin
							mreq.re    = pos_in;
							mreq.raddr = req.position;
						end
						FN_NEXT: begin
							mreq.re    = nxt_ok;
							mreq.raddr = cursor_q[IDX_W-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			ST_MOVE: begin
				mreq.we    = pend_q;
				mreq.waddr = dst_q;
				mreq.wdata = rdata;
				mreq.re    = (left_q != '0);
				mreq.raddr = idx_q;
			end
			ST_PLACE: begin
				mreq.we    = 1'b1;
				mreq.waddr = pos_q;
				mreq.wdata = val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
			left_q   <= '0;
			pos_q    <= '0;
			idx_q    <= '0;
			dst_q    <= '0;
			val_q    <= '0;
			ins_q    <= 1'b0;
			pend_q   <= 1'b0;
			fail_q   <= 1'b0;
			rd_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						pos_q   <= req.position;
						val_q   <= word_t'(req.value);
						fail_q  <= 1'b1;
						rd_q    <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= ST_RESP;
						case (req.func)
							FN_APPEND: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
									fail_q  <= 1'b0;
								end
							end
							FN_INSERT: begin
								if (!full && pos_le) begin
									count_q <= count_q + 1'b1;
									fail_q  <= 1'b0;
									ins_q   <= 1'b1;
									left_q  <= count_q - pos_ext;
									idx_q   <= IDX_W'(count_q - 1'b1);
									state_q <= ST_MOVE;
								end
							end
							FN_REMOVE: begin
								if (pos_in) begin
									count_q <= count_q - 1'b1;
									fail_q  <= 1'b0;
									ins_q   <= 1'b0;
									left_q  <= count_q - pos_ext - 1'b1;
									idx_q   <= req.position + 1'b1;
									state_q <= ST_MOVE;
								end
							end
							FN_SET: begin
								fail_q <= !pos_in;
							end
							FN_GET: begin
								fail_q <= !pos_in;
								rd_q   <= pos_in;
							end
							FN_RESET_CURSOR: begin
								cursor_q <= '0;
								fail_q   <= 1'b0;
							end
							FN_NEXT: begin
								if (nxt_ok) begin
									cursor_q <= cursor_q + 1'b1;
									fail_q   <= 1'b0;
									rd_q     <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MOVE: begin
					// Read one source while the previous one lands at its new place
					if (left_q != '0) begin
						pend_q <= 1'b1;
						left_q <= left_q - 1'b1;
						if (ins_q) begin
							dst_q <= idx_q + 1'b1;
							idx_q <= idx_q - 1'b1;
						end else begin
							dst_q <= idx_q - 1'b1;
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ins_q ? ST_PLACE : ST_RESP;
						end
					end
				end
				ST_PLACE: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid      = (state_q == ST_RESP);
	assign res.status     = fail_q;
	assign res.read_value = rd_q ? rdata : '0;
	assign res.length     = count_q;
	assign res.has_next   = (cursor_q < count_q);

endmodule
